/* rtl/broadcast_queue_late_join_defines.svh */
// Assertion macros used by the broadcast queue RTL.
`ifndef BROADCAST_QUEUE_LATE_JOIN_DEFINES_SVH
`define BROADCAST_QUEUE_LATE_JOIN_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BQLJ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("broadcast queue check failed");

// Next-cycle implication, checked outside reset.
`define BQLJ_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("broadcast queue sequencing check failed");

`endif

/* rtl/bqlj_pkg.sv */
// Types, constants and codes of the broadcast queue.
package bqlj_pkg;

    localparam int DEPTH   = 16;
    localparam int READERS = 4;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int JOIN_W  = $clog2(READERS + 1);
    localparam int RID_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_JOIN  = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;
    localparam logic [1:0] CMD_LEAVE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LJ_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LJ_WINDOW = 2'd1;

    typedef struct packed {
        logic [1:0]       command;
        logic [RID_W-1:0] reader_id;
        logic [31:0]      payload;
        logic [31:0]      msg_stamp;
        logic [31:0]      now_time;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [RID_W-1:0] assigned_reader;
        logic [31:0]      out_payload;
        logic [31:0]      out_stamp;
        logic [4:0]       stored_count;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [31:0]          wdata;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_JOIN,
        S_PUSH_AGE,
        S_PUSH_RETIRE,
        S_PUSH_STORE,
        S_POP,
        S_LEAVE
    } state_t;

endpackage

/* rtl/bqlj_req_if.sv */
// Request channel carrying one command item.
interface bqlj_req_if
    import bqlj_pkg::*;
;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/bqlj_rsp_if.sv */
// Response channel carrying one result item.
interface bqlj_rsp_if
    import bqlj_pkg::*;
;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/bqlj_cfg_if.sv */
// Configuration write channel.
interface bqlj_cfg_if
    import bqlj_pkg::*;
;
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/broadcast_queue_late_join.sv */
// Broadcast ring queue with per-reader delivery bits and late join window.
// A refused join or a pop with nothing pending ends at dispatch; a join walks the stored
// messages, a push skips, frees or retires slots before it stores, and a pop or leave
// examines slots in turn.
// Throughput: one request at a time; a new request is taken once the result
// has been delivered. Reset is asynchronous, active low, and empties the queue.
module broadcast_queue_late_join
    import bqlj_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bqlj_req_if.sink    req,
    bqlj_rsp_if.source  rsp,
    bqlj_cfg_if.sink    cfg
);

`include "broadcast_queue_late_join_defines.svh"

    // Message storage: written on push, read at the slot under inspection.
    logic [31:0] slot_payload [DEPTH];
    logic [31:0] slot_stamp   [DEPTH];

    state_t state_reg, state_next;

    // Latched request.
    logic [1:0]       cmd_reg;
    logic [RID_W-1:0] rid_reg, rid_next;
    logic [31:0]      pay_reg, stp_reg, now_reg;

    // Walk counter and push ageing index.
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Per-slot flags and totals.
    logic [READERS-1:0] taken_reg [DEPTH];
    logic [READERS-1:0] taken_next [DEPTH];
    logic [DEPTH-1:0]   held_reg, held_next, free_reg, free_next;
    logic [CNT_W-1:0]   ht_reg, ht_next, ft_reg, ft_next;

    // Per-reader state.
    logic [IDX_W-1:0]   rp_reg [READERS];
    logic [IDX_W-1:0]   rp_next [READERS];
    logic [CNT_W-1:0]   pend_reg [READERS];
    logic [CNT_W-1:0]   pend_next [READERS];
    logic [READERS-1:0] left_reg, left_next;

    logic [IDX_W-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]  mc_reg, mc_next;
    logic [JOIN_W-1:0] joined_reg, joined_next;

    // Configuration.
    logic        enable_reg;
    logic [31:0] window_reg;

    // Result register.
    logic out_valid_reg;
    rsp_t out_reg, out_next;
    logic finish;
    logic slot_write;

    // Shared slot selection and window compare unit.
    logic [IDX_W-1:0] slot_sel;
    logic [33:0]      age_diff;
    logic [33:0]      win_ext;
    logic             in_win;
    logic             found;
    logic             cnt_full;
    logic             all_joined;
    logic [31:0]      sel_stamp, sel_payload;

    logic req_fire;
    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        unique case (state_reg)
            S_JOIN:          slot_sel = tail_reg + cnt_reg[IDX_W-1:0];
            S_PUSH_AGE:      slot_sel = idx_reg;
            S_POP, S_LEAVE:  slot_sel = rp_reg[rid_reg];
            default:         slot_sel = idx_reg;
        endcase
    end

    assign sel_stamp   = slot_stamp[slot_sel];
    assign sel_payload = slot_payload[slot_sel];

    // Age is a signed difference; a stamp in the future counts as inside.
    assign age_diff   = {2'b00, now_reg} - {2'b00, sel_stamp};
    assign win_ext    = enable_reg ? {2'b00, window_reg} : 34'd0;
    assign in_win     = $signed(age_diff) <= $signed(win_ext);
    assign found      = !taken_reg[slot_sel][rid_reg];
    assign cnt_full   = cnt_reg >= CNT_W'(DEPTH);
    assign all_joined = joined_reg >= JOIN_W'(READERS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (cmd_reg)
                    CMD_JOIN:  state_next = all_joined ? S_IDLE : S_JOIN;
                    CMD_PUSH:  state_next = S_PUSH_AGE;
                    CMD_POP:   state_next = (pend_reg[rid_reg] == '0) ? S_IDLE : S_POP;
                    CMD_LEAVE: state_next = S_LEAVE;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_JOIN:
            begin
                if (cnt_reg >= mc_reg)
                    state_next = S_IDLE;
            end
            S_PUSH_AGE:
            begin
                if (ht_reg == '0 || cnt_full || (held_reg[idx_reg] && in_win))
                    state_next = S_PUSH_RETIRE;
            end
            S_PUSH_RETIRE:
            begin
                if (cnt_full || ft_reg == '0 || !free_reg[tail_reg])
                    state_next = S_PUSH_STORE;
            end
            S_PUSH_STORE:
                state_next = S_IDLE;
            S_POP:
            begin
                if (cnt_full || found)
                    state_next = S_IDLE;
            end
            S_LEAVE:
            begin
                if (pend_reg[rid_reg] == '0 || cnt_full)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign finish = (state_reg != S_IDLE) && (state_next == S_IDLE);

    // Datapath: one slot operation per cycle on the selected slot.
    always_comb
    begin
        logic [IDX_W-1:0] x;
        logic             alone;
        logic             check;
        rid_next    = rid_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        taken_next  = taken_reg;
        held_next   = held_reg;
        free_next   = free_reg;
        ht_next     = ht_reg;
        ft_next     = ft_reg;
        rp_next     = rp_reg;
        pend_next   = pend_reg;
        left_next   = left_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        mc_next     = mc_reg;
        joined_next = joined_reg;
        out_next    = out_reg;
        slot_write  = 1'b0;
        x           = slot_sel;
        alone       = 1'b1;
        check       = 1'b0;
        out_next.status          = ST_OK;
        out_next.assigned_reader = '0;
        out_next.out_payload     = '0;
        out_next.out_stamp       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_DISPATCH:
            begin
                cnt_next = '0;
                unique case (cmd_reg)
                    CMD_JOIN:
                    begin
                        if (all_joined)
                        begin
                            out_next.status = ST_REFUSED;
                        end
                        else
                        begin
                            rid_next = RID_W'(joined_reg);
                            rp_next[RID_W'(joined_reg)] = tail_reg;
                            joined_next = joined_reg + JOIN_W'(1);
                        end
                    end
                    CMD_PUSH:
                        idx_next = tail_reg;
                    CMD_POP:
                    begin
                        if (pend_reg[rid_reg] == '0)
                            out_next.status = ST_NONE;
                    end
                    CMD_LEAVE:
                        left_next[rid_reg] = 1'b1;
                    default:
                    begin
                    end
                endcase
            end
            S_JOIN:
            begin
                out_next.assigned_reader = rid_reg;
                if (cnt_reg < mc_reg)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (in_win)
                    begin
                        if (held_next[x])
                        begin
                            held_next[x] = 1'b0;
                            if (ht_next != '0)
                                ht_next = ht_next - CNT_W'(1);
                        end
                        if (taken_reg[x][rid_reg])
                        begin
                            taken_next[x][rid_reg] = 1'b0;
                            pend_next[rid_reg] = pend_reg[rid_reg] + CNT_W'(1);
                        end
                    end
                end
            end
            S_PUSH_AGE:
            begin
                if (ht_reg != '0 && !cnt_full)
                begin
                    if (!held_reg[idx_reg])
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else if (!in_win)
                    begin
                        check = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = '0;
                end
                if (state_next == S_PUSH_RETIRE)
                    cnt_next = '0;
            end
            S_PUSH_RETIRE:
            begin
                if (!cnt_full && ft_reg != '0 && free_reg[tail_reg])
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    free_next[tail_reg] = 1'b0;
                    ft_next = ft_reg - CNT_W'(1);
                    if (mc_next != '0)
                        mc_next = mc_next - CNT_W'(1);
                    tail_next = tail_reg + IDX_W'(1);
                end
            end
            S_PUSH_STORE:
            begin
                if (mc_reg >= CNT_W'(DEPTH))
                begin
                    out_next.status = ST_NONE;
                end
                else
                begin
                    slot_write = 1'b1;
                    if (held_next[head_reg])
                    begin
                        held_next[head_reg] = 1'b0;
                        if (ht_next != '0)
                            ht_next = ht_next - CNT_W'(1);
                    end
                    if (free_next[head_reg])
                    begin
                        free_next[head_reg] = 1'b0;
                        if (ft_next != '0)
                            ft_next = ft_next - CNT_W'(1);
                    end
                    mc_next = mc_reg + CNT_W'(1);
                    for (int i = 0; i < READERS; i++)
                    begin
                        if (JOIN_W'(i) < joined_reg && RID_W'(i) != rid_reg && !left_reg[i])
                        begin
                            alone = 1'b0;
                            pend_next[i] = pend_reg[i] + CNT_W'(1);
                            taken_next[head_reg][i] = 1'b0;
                        end
                        else
                        begin
                            taken_next[head_reg][i] = 1'b1;
                        end
                    end
                    if (alone && !held_next[head_reg])
                    begin
                        held_next[head_reg] = 1'b1;
                        ht_next = ht_next + CNT_W'(1);
                    end
                    head_next = head_reg + IDX_W'(1);
                end
            end
            S_POP, S_LEAVE:
            begin
                if (state_reg == S_LEAVE && pend_reg[rid_reg] == '0)
                begin
                end
                else if (cnt_full)
                begin
                    pend_next[rid_reg] = '0;
                    if (state_reg == S_POP)
                        out_next.status = ST_NONE;
                end
                else if (found)
                begin
                    if (state_reg == S_POP)
                    begin
                        out_next.out_payload = sel_payload;
                        out_next.out_stamp   = sel_stamp;
                    end
                    taken_next[x][rid_reg] = 1'b1;
                    pend_next[rid_reg] = pend_reg[rid_reg] - CNT_W'(1);
                    rp_next[rid_reg] = x + IDX_W'(1);
                    cnt_next = '0;
                    if (&taken_next[x])
                    begin
                        if (!held_next[x])
                        begin
                            held_next[x] = 1'b1;
                            ht_next = ht_next + CNT_W'(1);
                        end
                        if (all_joined || !in_win)
                            check = 1'b1;
                    end
                end
                else
                begin
                    rp_next[rid_reg] = x + IDX_W'(1);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        // Held to free on the selected slot; retire at once when it is the tail.
        if (check)
        begin
            if (held_next[x])
            begin
                held_next[x] = 1'b0;
                if (ht_next != '0)
                    ht_next = ht_next - CNT_W'(1);
            end
            if (!free_next[x])
            begin
                free_next[x] = 1'b1;
                ft_next = ft_next + CNT_W'(1);
            end
            if (tail_next == x)
            begin
                if (free_next[tail_next])
                begin
                    free_next[tail_next] = 1'b0;
                    if (ft_next != '0)
                        ft_next = ft_next - CNT_W'(1);
                end
                if (mc_next != '0)
                    mc_next = mc_next - CNT_W'(1);
                tail_next = tail_next + IDX_W'(1);
            end
        end

        out_next.stored_count = mc_next;
    end

    // Message storage writes.
    always_ff @(posedge clk)
    begin
        if (slot_write)
        begin
            slot_payload[head_reg] <= pay_reg;
            slot_stamp[head_reg]   <= stp_reg;
        end
    end

    // Latched request and result payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg <= req.data.command;
            pay_reg <= req.data.payload;
            stp_reg <= req.data.msg_stamp;
            now_reg <= req.data.now_time;
        end
        if (finish)
            out_reg <= out_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rid_reg       <= '0;
            cnt_reg       <= '0;
            held_reg      <= '0;
            free_reg      <= '0;
            ht_reg        <= '0;
            ft_reg        <= '0;
            left_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            mc_reg        <= '0;
            joined_reg    <= '0;
            enable_reg    <= 1'b0;
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
                taken_reg[i] <= '0;
            for (int r = 0; r < READERS; r++)
            begin
                rp_reg[r]   <= '0;
                pend_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            rid_reg    <= req_fire ? req.data.reader_id : rid_next;
            cnt_reg    <= cnt_next;
            taken_reg  <= taken_next;
            held_reg   <= held_next;
            free_reg   <= free_next;
            ht_reg     <= ht_next;
            ft_reg     <= ft_next;
            rp_reg     <= rp_next;
            pend_reg   <= pend_next;
            left_reg   <= left_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            mc_reg     <= mc_next;
            joined_reg <= joined_next;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                if (cfg.data.reg_index == REG_LJ_ENABLE)
                    enable_reg <= cfg.data.wdata[0];
                else if (cfg.data.reg_index == REG_LJ_WINDOW)
                    window_reg <= cfg.data.wdata;
            end
        end
    end

    // The ring never holds more than its depth, nor more readers than exist.
    `BQLJ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, mc_reg <= CNT_W'(DEPTH) && joined_reg <= JOIN_W'(READERS))
    // No new request while a command is still walking the ring.
    `BQLJ_ASSERT_NOW(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !req.ready)
    // An accepted request always starts with the dispatch cycle.
    `BQLJ_ASSERT_NEXT(a_dispatch, clk, rst_n, req_fire, state_reg == S_DISPATCH)
    // A result is raised only at the end of a command.
    `BQLJ_ASSERT_NEXT(a_result_end, clk, rst_n, !out_valid_reg && !finish, !out_valid_reg)

endmodule
